[design/assert_macros.svh]
// Assertion macros shared by the radix converter modules.
// Each macro expects signals named clock and reset in the enclosing module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked in the same cycle.
`define RC_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Implication checked in the next cycle.
`define RC_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

[design/rc_pkg.sv]
// Package for the radix converter: transfer payload types, microcode types,
// the microcode table and the reciprocal table. It depends on nothing else.
`timescale 1ns / 1ps

package rc_pkg;

   localparam int FUNC_W  = 2;
   localparam int NUM_W   = 31;
   localparam int RADIX_W = 4;
   localparam int TEXT_W  = 64;
   localparam int DIG_W   = 4;
   localparam int WGT_W   = 32;
   localparam int RECIP_W = 32;
   localparam int HACC_W  = 38;

   localparam logic [FUNC_W-1:0] FUNC_TO_RADIX   = 2'd0;
   localparam logic [FUNC_W-1:0] FUNC_FROM_RADIX = 2'd1;
   localparam logic [FUNC_W-1:0] FUNC_TO_HEX     = 2'd2;
   localparam logic [FUNC_W-1:0] FUNC_FROM_HEX   = 2'd3;

   localparam logic [NUM_W-1:0]   NUM_MAX   = '1;
   localparam logic [WGT_W-1:0]   WGT_SAT   = {1'b1, {(WGT_W-1){1'b0}}};
   localparam logic [RADIX_W-1:0] RADIX_MIN = 4'd2;
   localparam logic [RADIX_W-1:0] RADIX_DEC = 4'd10;
   localparam logic [DIG_W-1:0]   DIGIT_MAX = 4'd9;

   localparam logic [7:0] CHAR_ZERO     = 8'h30;
   localparam logic [7:0] CHAR_UPPER_A  = 8'h41;
   localparam logic [7:0] CHAR_A_OFFSET = 8'd55;

   typedef struct packed {
      logic [FUNC_W-1:0]  func;
      logic [NUM_W-1:0]   number_in;
      logic [RADIX_W-1:0] radix;
      logic [TEXT_W-1:0]  text_in;
   } req_type;

   typedef struct packed {
      logic [NUM_W-1:0]  number_out;
      logic [TEXT_W-1:0] text_out;
      logic              overflow;
   } rsp_type;

   typedef enum logic [6:0] {
      S_IDLE = 7'b0000001,
      S_QEST = 7'b0000010,
      S_QFIX = 7'b0000100,
      S_HEX  = 7'b0001000,
      S_TXT  = 7'b0010000,
      S_FIN  = 7'b0100000,
      S_EMIT = 7'b1000000
   } step_type;

   typedef enum logic [2:0] {
      OP_WAIT = 3'd0,
      OP_QEST = 3'd1,
      OP_QFIX = 3'd2,
      OP_HEX  = 3'd3,
      OP_TXT  = 3'd4,
      OP_FIN  = 3'd5,
      OP_EMIT = 3'd6
   } op_type;

   typedef enum logic [2:0] {
      COND_ALWAYS = 3'd0,
      COND_REQ    = 3'd1,
      COND_ZERO   = 3'd2,
      COND_LAST   = 3'd3,
      COND_FREE   = 3'd4
   } cond_type;

   typedef struct packed {
      op_type   op;
      cond_type cond;
      step_type taken;
      step_type fall;
   } ctrl_type;

   typedef struct packed {
      logic val_zero;
      logic cnt_last;
   } dp_stat_type;

   typedef struct packed {
      logic              req_valid;
      logic [FUNC_W-1:0] func;
      logic              out_free;
      logic              val_zero;
      logic              cnt_last;
   } seq_stat_type;

   function automatic ctrl_type microcode(input step_type s);
      ctrl_type w;
      unique case (s)
         S_IDLE:  w = '{OP_WAIT, COND_REQ,    S_IDLE, S_IDLE};
         S_QEST:  w = '{OP_QEST, COND_ZERO,   S_EMIT, S_QFIX};
         S_QFIX:  w = '{OP_QFIX, COND_ALWAYS, S_QEST, S_QEST};
         S_HEX:   w = '{OP_HEX,  COND_ZERO,   S_EMIT, S_HEX};
         S_TXT:   w = '{OP_TXT,  COND_LAST,   S_FIN,  S_TXT};
         S_FIN:   w = '{OP_FIN,  COND_ALWAYS, S_EMIT, S_EMIT};
         S_EMIT:  w = '{OP_EMIT, COND_FREE,   S_IDLE, S_EMIT};
         default: w = '{OP_WAIT, COND_ALWAYS, S_IDLE, S_IDLE};
      endcase
      return w;
   endfunction

   function automatic step_type dispatch(input logic [FUNC_W-1:0] func);
      step_type s;
      unique case (func)
         FUNC_TO_RADIX:   s = S_QEST;
         FUNC_FROM_RADIX: s = S_QEST;
         FUNC_TO_HEX:     s = S_HEX;
         FUNC_FROM_HEX:   s = S_TXT;
         default:         s = S_IDLE;
      endcase
      return s;
   endfunction

   function automatic logic [RADIX_W-1:0] clamp_radix(input logic [RADIX_W-1:0] r);
      logic [RADIX_W-1:0] c;
      priority if (r < RADIX_MIN) c = RADIX_MIN;
      else if (r > RADIX_DEC)     c = RADIX_DEC;
      else                        c = r;
      return c;
   endfunction

   // Floor of 2^32 divided by the radix; the quotient estimate is at most one short.
   function automatic logic [RECIP_W-1:0] recip(input logic [RADIX_W-1:0] r);
      logic [RECIP_W-1:0] m;
      unique case (r)
         4'd2:    m = 32'h8000_0000;
         4'd3:    m = 32'h5555_5555;
         4'd4:    m = 32'h4000_0000;
         4'd5:    m = 32'h3333_3333;
         4'd6:    m = 32'h2AAA_AAAA;
         4'd7:    m = 32'h2492_4924;
         4'd8:    m = 32'h2000_0000;
         4'd9:    m = 32'h1C71_C71C;
         default: m = 32'h1999_9999;
      endcase
      return m;
   endfunction

endpackage

[design/rc_sequencer.sv]
// Microcode sequencer of the radix converter: step register, control word table
// and conditional jumps. Depends on rc_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module rc_sequencer import rc_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  seq_stat_type stat,
   output ctrl_type     ctrl
);

   step_type step_ff;
   step_type step_in;
   step_type target;
   logic     cond_true;

   assign ctrl = microcode(step_ff);

   always_comb begin
      unique case (ctrl.cond)
         COND_ALWAYS: cond_true = 1'b1;
         COND_REQ:    cond_true = stat.req_valid;
         COND_ZERO:   cond_true = stat.val_zero;
         COND_LAST:   cond_true = stat.cnt_last;
         COND_FREE:   cond_true = stat.out_free;
         default:     cond_true = 1'b0;
      endcase
   end

   assign target  = (ctrl.cond == COND_REQ) ? dispatch(stat.func) : ctrl.taken;
   assign step_in = cond_true ? target : ctrl.fall;

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= S_IDLE;
      end else begin
         step_ff <= step_in;
      end
   end

   `RC_ASSERT_NEXT(a_start_leaves_idle, (ctrl.op == OP_WAIT) && stat.req_valid,
                   ctrl.op != OP_WAIT, "Accepted request did not start a program")

endmodule

[design/rc_datapath.sv]
// Datapath of the radix converter: digit division by reciprocal, weighted
// accumulation, hex text packing and parsing. Depends on rc_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module rc_datapath import rc_pkg::*; #(
   parameter int HEX_CHARS = 8
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  req_type     req,
   input  ctrl_type    ctrl,
   output dp_stat_type stat,
   output rsp_type     result
);

   localparam int CNT_W   = $clog2(HEX_CHARS + 1);
   localparam int TOP_BIT = HEX_CHARS * 8 - 1;
   localparam int QPROD_W = NUM_W + RECIP_W;
   localparam logic [CNT_W-1:0] CNT_LIMIT = CNT_W'(HEX_CHARS);
   localparam logic [CNT_W-1:0] CNT_FIRST = CNT_W'(HEX_CHARS - 1);

   logic [NUM_W-1:0]         val_ff, val_in;
   logic [NUM_W-1:0]         qest_ff, qest_in;
   logic [RADIX_W-1:0]       src_ff, src_in;
   logic [RADIX_W-1:0]       dst_ff, dst_in;
   logic [DIG_W-1:0]         dig_ff, dig_in;
   logic [TEXT_W-1:0]        chars_ff, chars_in;
   logic signed [HACC_W-1:0] hacc_ff, hacc_in;
   logic                     pend_ff, pend_in;
   logic                     ovf_ff, ovf_in;
   logic [NUM_W-1:0]         acc_ff, acc_in;
   logic [WGT_W-1:0]         wgt_ff, wgt_in;
   logic [FUNC_W-1:0]        func_ff, func_in;
   logic [CNT_W-1:0]         cnt_ff, cnt_in;
   logic                     started_ff, started_in;

   logic [RADIX_W-1:0]       radix_c;
   logic [QPROD_W-1:0]       qprod;
   logic [DIG_W+WGT_W-1:0]   mac_term;
   logic [DIG_W+WGT_W:0]     mac_sum;
   logic                     mac_ovf;
   logic [RADIX_W+WGT_W-1:0] wgt_prod;
   logic [WGT_W-1:0]         wgt_next;
   logic [NUM_W+RADIX_W-1:0] fix_prod;
   logic [NUM_W-1:0]         fix_diff;
   logic [4:0]               rem;
   logic [4:0]               rem_adj;
   logic                     fix_over;
   logic [DIG_W-1:0]         nib;
   logic [7:0]               hex_char;
   logic [7:0]               cur_byte;
   logic signed [8:0]        txt_digit;
   logic signed [HACC_W-1:0] hacc_next;

   assign radix_c = clamp_radix(req.radix);

   assign qprod    = {{RECIP_W{1'b0}}, val_ff} * {{NUM_W{1'b0}}, recip(src_ff)};
   assign mac_term = {{WGT_W{1'b0}}, dig_ff} * {{DIG_W{1'b0}}, wgt_ff};
   assign mac_sum  = {{(DIG_W+WGT_W+1-NUM_W){1'b0}}, acc_ff} + {1'b0, mac_term};
   assign mac_ovf  = wgt_ff[WGT_W-1]
                     || (mac_sum > {{(DIG_W+WGT_W+1-NUM_W){1'b0}}, NUM_MAX});
   assign wgt_prod = {{RADIX_W{1'b0}}, wgt_ff} * {{WGT_W{1'b0}}, dst_ff};
   assign wgt_next = (wgt_ff[WGT_W-1] || (wgt_prod > {{RADIX_W{1'b0}}, WGT_SAT}))
                     ? WGT_SAT : wgt_prod[WGT_W-1:0];

   assign fix_prod = {{RADIX_W{1'b0}}, qest_ff} * {{NUM_W{1'b0}}, src_ff};
   assign fix_diff = val_ff - fix_prod[NUM_W-1:0];
   assign rem      = fix_diff[4:0];
   assign rem_adj  = rem - {1'b0, src_ff};
   assign fix_over = rem >= {1'b0, src_ff};

   assign nib      = val_ff[DIG_W-1:0];
   assign hex_char = (nib > DIGIT_MAX) ? (CHAR_A_OFFSET + {4'd0, nib})
                                       : (CHAR_ZERO + {4'd0, nib});

   assign cur_byte  = chars_ff[TOP_BIT -: 8];
   assign txt_digit = (cur_byte >= CHAR_UPPER_A)
                      ? $signed({1'b0, cur_byte} - {1'b0, CHAR_A_OFFSET})
                      : $signed({1'b0, cur_byte} - {1'b0, CHAR_ZERO});
   assign hacc_next = (hacc_ff <<< 4) + {{(HACC_W-9){txt_digit[8]}}, txt_digit};

   always_comb begin
      val_in     = val_ff;
      qest_in    = qest_ff;
      src_in     = src_ff;
      dst_in     = dst_ff;
      dig_in     = dig_ff;
      chars_in   = chars_ff;
      hacc_in    = hacc_ff;
      pend_in    = pend_ff;
      ovf_in     = ovf_ff;
      acc_in     = acc_ff;
      wgt_in     = wgt_ff;
      func_in    = func_ff;
      cnt_in     = cnt_ff;
      started_in = started_ff;
      unique case (ctrl.op)
         OP_WAIT: begin
            if (start) begin
               val_in     = req.number_in;
               src_in     = (req.func == FUNC_TO_RADIX) ? radix_c : RADIX_DEC;
               dst_in     = (req.func == FUNC_TO_RADIX) ? RADIX_DEC : radix_c;
               chars_in   = (req.func == FUNC_FROM_HEX) ? req.text_in : '0;
               hacc_in    = '0;
               pend_in    = 1'b0;
               ovf_in     = 1'b0;
               acc_in     = '0;
               wgt_in     = WGT_W'(1);
               func_in    = req.func;
               cnt_in     = (req.func == FUNC_FROM_HEX) ? CNT_FIRST : '0;
               started_in = 1'b0;
            end
         end
         OP_QEST: begin
            qest_in = qprod[QPROD_W-1:RECIP_W];
            if (pend_ff) begin
               pend_in = 1'b0;
               wgt_in  = wgt_next;
               if (dig_ff != '0) begin
                  if (mac_ovf) begin
                     ovf_in = 1'b1;
                     acc_in = NUM_MAX;
                  end else begin
                     acc_in = mac_sum[NUM_W-1:0];
                  end
               end
            end
         end
         OP_QFIX: begin
            val_in  = fix_over ? (qest_ff + NUM_W'(1)) : qest_ff;
            dig_in  = fix_over ? rem_adj[DIG_W-1:0] : rem[DIG_W-1:0];
            pend_in = 1'b1;
         end
         OP_HEX: begin
            if (val_ff != '0) begin
               if (cnt_ff < CNT_LIMIT) begin
                  for (int i = 0; i < HEX_CHARS; i++) begin
                     if (cnt_ff == CNT_W'(i)) begin
                        chars_in[i*8 +: 8] = hex_char;
                     end
                  end
                  cnt_in = cnt_ff + CNT_W'(1);
               end else begin
                  ovf_in = 1'b1;
               end
               val_in = val_ff >> 4;
            end
         end
         OP_TXT: begin
            if (started_ff || (cur_byte != 8'd0)) begin
               hacc_in    = hacc_next;
               started_in = 1'b1;
            end
            chars_in = chars_ff << 8;
            if (cnt_ff != '0) begin
               cnt_in = cnt_ff - CNT_W'(1);
            end
         end
         OP_FIN: begin
            priority if (hacc_ff[HACC_W-1]) begin
               acc_in = '0;
            end else if (|hacc_ff[HACC_W-2:NUM_W]) begin
               acc_in = NUM_MAX;
               ovf_in = 1'b1;
            end else begin
               acc_in = hacc_ff[NUM_W-1:0];
            end
         end
         OP_EMIT: begin
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff    <= 1'b0;
         ovf_ff     <= 1'b0;
         acc_ff     <= '0;
         wgt_ff     <= '0;
         func_ff    <= FUNC_TO_RADIX;
         cnt_ff     <= '0;
         started_ff <= 1'b0;
      end else begin
         pend_ff    <= pend_in;
         ovf_ff     <= ovf_in;
         acc_ff     <= acc_in;
         wgt_ff     <= wgt_in;
         func_ff    <= func_in;
         cnt_ff     <= cnt_in;
         started_ff <= started_in;
      end
   end

   always_ff @(posedge clock) begin
      val_ff   <= val_in;
      qest_ff  <= qest_in;
      src_ff   <= src_in;
      dst_ff   <= dst_in;
      dig_ff   <= dig_in;
      chars_ff <= chars_in;
      hacc_ff  <= hacc_in;
   end

   assign stat.val_zero = (val_ff == '0);
   assign stat.cnt_last = (cnt_ff == '0);

   assign result.number_out = (func_ff == FUNC_TO_HEX) ? '0 : acc_ff;
   assign result.text_out   = (func_ff == FUNC_TO_HEX) ? chars_ff : '0;
   assign result.overflow   = ovf_ff;

   `RC_ASSERT_NOW(a_no_digit_left, ctrl.op == OP_EMIT, !pend_ff,
                  "Result emitted with a digit not yet accumulated")
   `RC_ASSERT_NOW(a_ovf_saturates, ovf_ff && (func_ff != FUNC_TO_HEX), acc_ff == NUM_MAX,
                  "Overflow raised without a saturated value")

endmodule

[design/radix_converter.sv]
// Radix converter top level: request and response transfers, output register,
// sequencer and datapath. Depends on rc_pkg, rc_sequencer, rc_datapath, assert_macros.svh.
//
// Each request transfer on req_ carries func, number_in, radix and text_in and
// yields exactly one response transfer on rsp_ with number_out, text_out and
// overflow. func selects: write in radix as a decimal-coded numeral, read a
// decimal-coded numeral in radix, number to hex text, or hex text to number.
// One request is worked on at a time; req_stall is low only while the
// sequencer waits for work. For each digit of number_in in the source radix
// the program runs a reciprocal multiply step and a remainder correction step;
// it then adds the last digit and emits the response once the output is free.
// Hex text output packs characters from the low nibble up until the number is
// zero; hex text input parses all HEX_CHARS characters, then clamps the result.
// The next request is taken once the response is registered, even if the
// receiver still stalls it; a second result then waits in the program until the
// output register is free. Reset is synchronous and returns the sequencer to idle with no response pending.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module radix_converter import rc_pkg::*; #(
   parameter int HEX_CHARS = 8
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   ctrl_type     ctrl;
   seq_stat_type seq_stat;
   dp_stat_type  dp_stat;
   rsp_type      result;
   logic         start;
   logic         out_free;
   logic         emit;

   logic         rsp_valid_ff, rsp_valid_in;
   rsp_type      rsp_data_ff, rsp_data_in;

   assign req_stall = (ctrl.op != OP_WAIT);
   assign start     = req_valid && !req_stall;
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign emit      = (ctrl.op == OP_EMIT) && out_free;

   assign seq_stat.req_valid = req_valid;
   assign seq_stat.func      = req_data.func;
   assign seq_stat.out_free  = out_free;
   assign seq_stat.val_zero  = dp_stat.val_zero;
   assign seq_stat.cnt_last  = dp_stat.cnt_last;

   rc_sequencer u_seq (
      .clock (clock),
      .reset (reset),
      .stat  (seq_stat),
      .ctrl  (ctrl)
   );

   rc_datapath #(
      .HEX_CHARS (HEX_CHARS)
   ) u_dp (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .req    (req_data),
      .ctrl   (ctrl),
      .stat   (dp_stat),
      .result (result)
   );

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      priority if (emit) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = result;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   `RC_ASSERT_NEXT(a_emit_returns_idle, emit, rsp_valid_ff && (ctrl.op == OP_WAIT),
                   "Emitted result not registered or program not back at idle")
   `RC_ASSERT_NEXT(a_emit_waits, (ctrl.op == OP_EMIT) && !out_free, ctrl.op == OP_EMIT,
                   "Result left the program while the output register was full")

endmodule
